@@ sv/iir_filter_direct_form_one_macros.svh @@
// ----------------------------------------------------------------------------
// iir filter assertion macros
// concurrent assertion shorthands, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define IIRF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("iirf assertion failed");
// next-cycle implication
`define IIRF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("iirf assertion failed");
`else
`define IIRF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define IIRF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

@@ sv/iirf_pkg.sv @@
// ----------------------------------------------------------------------------
// iir filter package
// widths, register codes and coefficient bundle for the biquad filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iirf_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 18;
	localparam int FRAC_W       = 14;
	localparam int PROD_W       = SAMPLE_W + COEF_W;
	localparam int FF_W         = PROD_W + 2;
	localparam int ACC_W        = PROD_W + 3;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam int TAPS_DEFAULT = 3;

	localparam logic signed [COEF_W-1:0]   COEF_UNITY = 18'sd16384;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	// register index, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_FF0,
		REG_FF1,
		REG_FF2,
		REG_FB1,
		REG_FB2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ff0;
		logic signed [COEF_W-1:0] ff1;
		logic signed [COEF_W-1:0] ff2;
		logic signed [COEF_W-1:0] fb1;
		logic signed [COEF_W-1:0] fb2;
	} coef_set_t;

endpackage

`default_nettype wire

@@ sv/iirf_in_if.sv @@
// ----------------------------------------------------------------------------
// iir filter input channel
// valid/ready channel carrying one input sample per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iirf_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [iirf_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

@@ sv/iirf_out_if.sv @@
// ----------------------------------------------------------------------------
// iir filter output channel
// valid/ready channel carrying one filtered sample and its clip flag per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iirf_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [iirf_pkg::SAMPLE_W-1:0] sample_out;
	logic                                 clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

@@ sv/iir_filter_direct_form_one.sv @@
// ----------------------------------------------------------------------------
// iir filter, direct form one biquad
// second-order fixed-point iir filter with q3.14 coefficients
// ----------------------------------------------------------------------------
// usage
//  - sample_ch takes one signed 16-bit sample per word (valid/ready)
//  - result_ch gives the rounded, saturated output and a clip flag per word
//  - coefficients are written over the apb-style port while no word is in
//    flight: ff_coef_0..2 at 0x00..0x08, fb_coef_1..2 at 0x0c..0x10
//  - a word accepted on sample_ch shows on result_ch after a three-register
//    path: products, feedforward sum, output register
//  - throughput: one word per cycle while result_ch does not stall; the
//    feedback loop (two tap cells of the output chain, the subtract, round
//    and saturate) closes combinationally into the output register
//  - a stall on result_ch holds the output register; words keep being taken
//    until the two internal stages are full, then sample_ch drops ready
//  - reset clears all history to zero, ff_coef_0 to 1.0 and the rest to 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "iir_filter_direct_form_one_macros.svh"

module iir_filter_direct_form_one #(
	parameter int TAPS = iirf_pkg::TAPS_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [iirf_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [iirf_pkg::DATA_W-1:0]   pwdata,
	output logic      [iirf_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,
	iirf_in_if.sink                            sample_ch,
	iirf_out_if.source                         result_ch
);
	import iirf_pkg::*;

	localparam int Q_W = ACC_W - FRAC_W;
	localparam logic signed [Q_W-1:0]   Q_HI  = Q_W'(SAMPLE_MAX);
	localparam logic signed [Q_W-1:0]   Q_LO  = Q_W'(SAMPLE_MIN);
	localparam logic signed [ACC_W-1:0] RND_K = ACC_W'(1) <<< (FRAC_W - 1);

	// coefficient registers
	coef_set_t                coefs;
	logic signed [COEF_W-1:0] ff_coef_w [0:2];
	logic signed [COEF_W-1:0] fb_coef_w [1:2];

	iirf_coef_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	assign ff_coef_w[0] = coefs.ff0;
	assign ff_coef_w[1] = coefs.ff1;
	assign ff_coef_w[2] = coefs.ff2;
	assign fb_coef_w[1] = coefs.fb1;
	assign fb_coef_w[2] = coefs.fb2;

	// handshake through the three stages
	logic valid_s1, valid_s2, valid_out_q;
	logic ready_s1, ready_s2, ready_out;
	logic in_acc, adv_out;

	assign ready_out = !valid_out_q || result_ch.ready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_acc    = sample_ch.valid && ready_s1;
	assign adv_out   = valid_s2 && ready_out;

	assign sample_ch.ready = ready_s1;

	// input delay chain: link k carries x[n-k], each cell multiplies its tap
	logic signed [SAMPLE_W-1:0] x_link [0:TAPS-1];
	logic signed [PROD_W-1:0]   x_prod [0:TAPS-1];

	assign x_link[0] = sample_ch.sample_in;
	assign x_prod[0] = PROD_W'(ff_coef_w[0]) * PROD_W'(sample_ch.sample_in);

	// output delay chain: link 0 is the new y, link k holds y[n-k]
	logic signed [SAMPLE_W-1:0] y_link [0:TAPS-1];
	logic signed [PROD_W-1:0]   y_prod [0:TAPS-1];
	logic signed [SAMPLE_W-1:0] y_w;
	logic                       clip_w;

	assign y_link[0] = y_w;
	assign y_prod[0] = '0;

	for (genvar k = 1; k < TAPS; k++) begin : g_taps
		iirf_tap_cell u_x_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift_en    (in_acc),
			.prev_sample (x_link[k-1]),
			.coef        (ff_coef_w[k]),
			.held        (x_link[k]),
			.prod        (x_prod[k])
		);

		iirf_tap_cell u_y_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.shift_en    (adv_out),
			.prev_sample (y_link[k-1]),
			.coef        (fb_coef_w[k]),
			.held        (y_link[k]),
			.prod        (y_prod[k])
		);
	end

	// stage 1: registered feedforward products
	logic signed [PROD_W-1:0] prod_s1 [0:TAPS-1];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			prod_s1 <= x_prod;
		end
	end

	// stage 2: feedforward sum
	logic signed [FF_W-1:0] ff_sum_w;
	logic signed [FF_W-1:0] ff_s2;

	always_comb begin
		ff_sum_w = '0;
		for (int k = 0; k < TAPS; k++) begin
			ff_sum_w = ff_sum_w + FF_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			ff_s2 <= ff_sum_w;
		end
	end

	// feedback, round half up and saturate
	logic signed [ACC_W-1:0] acc_w;
	logic signed [ACC_W-1:0] rnd_w;
	logic signed [Q_W-1:0]   q_w;

	always_comb begin
		acc_w = ACC_W'(ff_s2);
		for (int k = 1; k < TAPS; k++) begin
			acc_w = acc_w - ACC_W'(y_prod[k]);
		end
		rnd_w = acc_w + RND_K;
		q_w   = rnd_w[ACC_W-1:FRAC_W];
		if (q_w > Q_HI) begin
			y_w    = SAMPLE_MAX;
			clip_w = 1'b1;
		end else if (q_w < Q_LO) begin
			y_w    = SAMPLE_MIN;
			clip_w = 1'b1;
		end else begin
			y_w    = q_w[SAMPLE_W-1:0];
			clip_w = 1'b0;
		end
	end

	// output register
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       clipped_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			sample_out_q <= y_w;
			clipped_q    <= clip_w;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_out_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample_ch.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				valid_out_q <= valid_s2;
			end
		end
	end

	assign result_ch.valid      = valid_out_q;
	assign result_ch.sample_out = sample_out_q;
	assign result_ch.clipped    = clipped_q;

	// assertions
	`IIRF_ASSERT_IMP(a_clip_on_rail, clk, arst_n, valid_out_q && clipped_q,
		sample_out_q == SAMPLE_MAX || sample_out_q == SAMPLE_MIN)

	if (TAPS > 1) begin : g_hist_checks
		`IIRF_ASSERT_IMP(a_y_hist_head, clk, arst_n, valid_out_q, y_link[1] == sample_out_q)
		`IIRF_ASSERT_NXT(a_x_hist_head, clk, arst_n, in_acc,
			x_link[1] == $past(sample_ch.sample_in))
	end

endmodule

`default_nettype wire

@@ sv/iirf_tap_cell.sv @@
// ----------------------------------------------------------------------------
// iir filter tap cell
// one history register of a delay chain and its coefficient product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iirf_tap_cell (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 shift_en,
	input  wire logic signed [iirf_pkg::SAMPLE_W-1:0] prev_sample,
	input  wire logic signed [iirf_pkg::COEF_W-1:0]   coef,
	output logic signed [iirf_pkg::SAMPLE_W-1:0]      held,
	output logic signed [iirf_pkg::PROD_W-1:0]        prod
);
	import iirf_pkg::*;

	logic signed [SAMPLE_W-1:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (shift_en) begin
			held_q <= prev_sample;
		end
	end

	assign held = held_q;
	assign prod = PROD_W'(coef) * PROD_W'(held_q);

endmodule

`default_nettype wire

@@ sv/iirf_coef_regs.sv @@
// ----------------------------------------------------------------------------
// iir filter coefficient registers
// apb-style register file holding the five q3.14 coefficients
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iirf_coef_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [iirf_pkg::ADDR_W-1:0]        paddr,
	input  wire logic [iirf_pkg::DATA_W-1:0]        pwdata,
	output logic      [iirf_pkg::DATA_W-1:0]        prdata,
	output logic                                    pready,
	output iirf_pkg::coef_set_t                     coefs
);
	import iirf_pkg::*;

	coef_set_t                coef_q;
	reg_idx_t                 idx_w;
	logic                     wr_w;
	logic signed [COEF_W-1:0] wval_w;

	assign idx_w  = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_w   = psel && penable && pwrite;
	assign wval_w = pwdata[COEF_W-1:0];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// unity pass-through: ff0 at 1.0, all other taps off
			coef_q <= coef_set_t'{COEF_UNITY, '0, '0, '0, '0};
		end else if (wr_w) begin
			unique case (idx_w)
				REG_FF0: coef_q.ff0 <= wval_w;
				REG_FF1: coef_q.ff1 <= wval_w;
				REG_FF2: coef_q.ff2 <= wval_w;
				REG_FB1: coef_q.fb1 <= wval_w;
				REG_FB2: coef_q.fb2 <= wval_w;
				default: ;
			endcase
		end
	end

	// reads return the coefficient sign-extended
	always_comb begin
		unique case (idx_w)
			REG_FF0: prdata = DATA_W'(coef_q.ff0);
			REG_FF1: prdata = DATA_W'(coef_q.ff1);
			REG_FF2: prdata = DATA_W'(coef_q.ff2);
			REG_FB1: prdata = DATA_W'(coef_q.fb1);
			REG_FB2: prdata = DATA_W'(coef_q.fb2);
			default: prdata = '0;
		endcase
	end

	assign coefs = coef_q;

endmodule

`default_nettype wire
